// ===== hw/rtl/hkrt_pkg.sv =====
// hkrt_pkg: shared types and constants of the keyboard report tracker
// depends on nothing; imported by every module of the block but hkrt_ram
`default_nettype none

package hkrt_pkg;

  // report ring size and index width
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);

  // key slots and modifier bits in one report
  localparam int unsigned NUM_KEYS = 6;
  localparam int unsigned NUM_MODS = 8;

  localparam logic [7:0] COUNT_MAX  = 8'd255;
  localparam logic [7:0] LEFT_SHIFT = 8'h02;

  // action codes of an input transfer
  typedef enum logic [2:0] {
    ACT_KEY_PRESS   = 3'd0,
    ACT_KEY_RELEASE = 3'd1,
    ACT_MOD_PRESS   = 3'd2,
    ACT_MOD_RELEASE = 3'd3,
    ACT_RELEASE_ALL = 3'd4,
    ACT_TYPE_ONCE   = 3'd5,
    ACT_POLL        = 3'd6
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] key_code;
    logic       needs_shift;
    logic [2:0] modifier_index;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       report_valid;
    logic [7:0] report_modifiers;
    logic [7:0] report_key0;
    logic [7:0] report_key1;
    logic [7:0] report_key2;
    logic [7:0] report_key3;
    logic [7:0] report_key4;
    logic [7:0] report_key5;
    logic       report_lost;
  } res_t;

  // one ring entry: modifiers, six keys, one-shot mark
  typedef struct packed {
    logic [7:0]                   mods;
    logic [NUM_KEYS-1:0][7:0]     keys;
    logic                         one_shot;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hkrt_ram.sv =====
// hkrt_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`default_nettype none

module hkrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hkrt_ctrl.sv =====
// hkrt_ctrl: controller state machine, sequences capture and execute of a transfer
// depends on hkrt_pkg
`default_nettype none

module hkrt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  output logic                    done_o,
  output hkrt_pkg::ctrl_cmd_t     cmd_o
);

  import hkrt_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // state and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    busy_o    = 1'b0;
    done_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hkrt_dp.sv =====
// hkrt_dp: datapath with key slots, reference counts, ring pointers and result register
// depends on hkrt_pkg; drives the ports of the report ring RAM
`default_nettype none

module hkrt_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hkrt_pkg::ctrl_cmd_t           cmd_i,
  input  wire hkrt_pkg::item_t               item_i,
  output logic                               ram_we_o,
  output logic      [hkrt_pkg::QIDX_W-1:0]   ram_waddr_o,
  output hkrt_pkg::entry_t                   ram_wdata_o,
  output logic      [hkrt_pkg::QIDX_W-1:0]   ram_raddr_o,
  input  wire hkrt_pkg::entry_t              ram_rdata_i,
  output hkrt_pkg::res_t                     result_o
);

  import hkrt_pkg::*;

  // captured transfer and result
  item_t item_q;
  res_t  res_q, res_d;

  // tracker state
  logic [NUM_KEYS-1:0][7:0] held_q, held_d;
  logic [NUM_KEYS-1:0][7:0] kcnt_q, kcnt_d;
  logic [NUM_MODS-1:0][7:0] mcnt_q, mcnt_d;
  logic [7:0]               shift_cnt_q, shift_cnt_d;
  logic [QIDX_W-1:0]        head_q, head_d;
  logic [QIDX_W-1:0]        tail_q, tail_d;
  logic                     rel_pend_q, rel_pend_d;
  logic                     last_os_q, last_os_d;

  // slot search
  logic [NUM_KEYS-1:0] hit_sel, emp_sel;
  logic                hit_any, emp_any;

  // ring helpers
  logic [QIDX_W-1:0] head_next, head_last;
  logic              ring_full;

  // enqueue request
  logic       push, push_os, lost;
  logic [7:0] state_mods;
  entry_t     new_entry;

  // payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      kcnt_q      <= '0;
      mcnt_q      <= '0;
      shift_cnt_q <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      rel_pend_q  <= 1'b0;
      last_os_q   <= 1'b0;
    end else begin
      held_q      <= held_d;
      kcnt_q      <= kcnt_d;
      mcnt_q      <= mcnt_d;
      shift_cnt_q <= shift_cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rel_pend_q  <= rel_pend_d;
      last_os_q   <= last_os_d;
    end
  end

  // first matching slot and first empty slot
  always_comb begin
    hit_sel = '0;
    emp_sel = '0;
    hit_any = 1'b0;
    emp_any = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (!hit_any && held_q[i] == item_q.key_code) begin
        hit_sel[i] = 1'b1;
        hit_any    = 1'b1;
      end
      if (!emp_any && held_q[i] == 8'd0) begin
        emp_sel[i] = 1'b1;
        emp_any    = 1'b1;
      end
    end
  end

  // ring pointer arithmetic
  assign head_next = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_last = (head_q == '0) ? QIDX_W'(QUEUE_DEPTH - 1) : head_q - 1'b1;
  assign ring_full = (head_next == tail_q);

  // read the entry at the tail every cycle; data is ready during execute
  assign ram_raddr_o = tail_q;

  // action execution
  always_comb begin
    held_d      = held_q;
    kcnt_d      = kcnt_q;
    mcnt_d      = mcnt_q;
    shift_cnt_d = shift_cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rel_pend_d  = rel_pend_q;
    last_os_d   = last_os_q;
    res_d       = '0;
    push        = 1'b0;
    push_os     = 1'b0;
    lost        = 1'b0;
    state_mods  = '0;
    new_entry   = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_q;

    if (cmd_i.exec) begin
      unique case (item_q.action)
        ACT_KEY_PRESS: begin
          if (item_q.key_code != 8'd0 && (hit_any || emp_any)) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
              if (hit_any) begin
                if (hit_sel[i] && kcnt_q[i] != COUNT_MAX) begin
                  kcnt_d[i] = kcnt_q[i] + 8'd1;
                end
              end else if (emp_sel[i]) begin
                held_d[i] = item_q.key_code;
                kcnt_d[i] = 8'd1;
              end
            end
            if (item_q.needs_shift && shift_cnt_q != COUNT_MAX) begin
              shift_cnt_d = shift_cnt_q + 8'd1;
            end
            push           = 1'b1;
            res_d.accepted = 1'b1;
          end
        end
        ACT_KEY_RELEASE: begin
          if (item_q.key_code != 8'd0 && hit_any) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
              if (hit_sel[i]) begin
                if (kcnt_q[i] > 8'd1) begin
                  kcnt_d[i] = kcnt_q[i] - 8'd1;
                end else begin
                  kcnt_d[i] = 8'd0;
                  held_d[i] = 8'd0;
                end
              end
            end
            if (item_q.needs_shift && shift_cnt_q != 8'd0) begin
              shift_cnt_d = shift_cnt_q - 8'd1;
            end
            push           = 1'b1;
            res_d.accepted = 1'b1;
          end
        end
        ACT_MOD_PRESS: begin
          if (mcnt_q[item_q.modifier_index] != COUNT_MAX) begin
            mcnt_d[item_q.modifier_index] = mcnt_q[item_q.modifier_index] + 8'd1;
          end
          push           = 1'b1;
          res_d.accepted = 1'b1;
        end
        ACT_MOD_RELEASE: begin
          if (mcnt_q[item_q.modifier_index] != 8'd0) begin
            mcnt_d[item_q.modifier_index] = mcnt_q[item_q.modifier_index] - 8'd1;
          end
          push           = 1'b1;
          res_d.accepted = 1'b1;
        end
        ACT_RELEASE_ALL: begin
          held_d         = '0;
          kcnt_d         = '0;
          mcnt_d         = '0;
          shift_cnt_d    = '0;
          push           = 1'b1;
          res_d.accepted = 1'b1;
        end
        ACT_TYPE_ONCE: begin
          if (item_q.key_code != 8'd0) begin
            push           = 1'b1;
            push_os        = 1'b1;
            res_d.accepted = 1'b1;
          end
        end
        ACT_POLL: begin
          if (head_q != tail_q) begin
            res_d.report_valid = 1'b1;
            if (rel_pend_q) begin
              // release half of a one-shot: all-zero report
              rel_pend_d = 1'b0;
              tail_d     = (tail_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
            end else begin
              res_d.report_modifiers = ram_rdata_i.mods;
              res_d.report_key0      = ram_rdata_i.keys[0];
              res_d.report_key1      = ram_rdata_i.keys[1];
              res_d.report_key2      = ram_rdata_i.keys[2];
              res_d.report_key3      = ram_rdata_i.keys[3];
              res_d.report_key4      = ram_rdata_i.keys[4];
              res_d.report_key5      = ram_rdata_i.keys[5];
              if (ram_rdata_i.one_shot) begin
                rel_pend_d = 1'b1;
              end else begin
                tail_d = (tail_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
              end
            end
          end
        end
        default: begin
          // unused code: no effect
        end
      endcase

      // report of the updated state
      for (int i = 0; i < NUM_MODS; i++) begin
        state_mods[i] = (mcnt_d[i] != 8'd0);
      end
      if (shift_cnt_d != 8'd0) begin
        state_mods = state_mods | LEFT_SHIFT;
      end

      if (push_os) begin
        new_entry.mods     = item_q.needs_shift ? LEFT_SHIFT : 8'd0;
        new_entry.keys[0]  = item_q.key_code;
        new_entry.one_shot = 1'b1;
      end else begin
        new_entry.mods     = state_mods;
        new_entry.keys     = held_d;
        new_entry.one_shot = 1'b0;
      end

      // enqueue, merge into the newest state entry, or drop
      if (push) begin
        if (ring_full) begin
          if (!push_os && !last_os_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = head_last;
          end else begin
            lost = 1'b1;
          end
        end else begin
          ram_we_o  = 1'b1;
          head_d    = head_next;
          last_os_d = push_os;
        end
      end
      res_d.report_lost = lost;
    end
  end

  assign ram_wdata_o = new_entry;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hid_keyboard_report_tracker.sv =====
// hid_keyboard_report_tracker: top level, joins controller, datapath and report ring
// depends on hkrt_pkg, hkrt_ctrl, hkrt_dp, hkrt_ram
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------
//   input    | start_i / busy_o   | item_i   (hkrt_pkg::item_t)
//   result   | done_o (strobe)    | result_o (hkrt_pkg::res_t)
//
// Each transfer is captured, then executed in ST_EXEC, which updates the counts and
// writes the ring; the result strobes in the cycle after execute.
// The ring RAM is read at the tail while a transfer is captured, so a poll has its
// entry in the execute cycle; one write and one read port are enough.
// Reset clears counts, key slots and ring pointers at once; ring contents are not cleared.
// The receiver cannot stall: done_o is high for exactly one cycle per transfer.
`default_nettype none

module hid_keyboard_report_tracker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire hkrt_pkg::item_t  item_i,
  output logic                  done_o,
  output hkrt_pkg::res_t        result_o
);

  import hkrt_pkg::*;

  ctrl_cmd_t         cmd;
  logic              ram_we;
  logic [QIDX_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  // controller
  hkrt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // datapath
  hkrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .result_o    (result_o)
  );

  // report ring
  hkrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  // an accepted transfer makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer accepted without execute cycle");

  // execute is always followed in the next cycle by the result strobe, with busy low again
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (done_o && !busy_o))
    else $error("execute not followed by result");

  // a poll never reports a key action as taken
  a_poll_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.report_valid) |-> !result_o.accepted)
    else $error("poll result marked accepted");

  // only an action that took effect can lose its report
  a_lost_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.report_lost) |-> result_o.accepted)
    else $error("report lost on an ignored action");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/hid_keyboard_report_tracker_tb.sv =====
// hid_keyboard_report_tracker_tb: self-checking bench for the keyboard report tracker
// depends on hkrt_pkg and hid_keyboard_report_tracker; a queue-fed driver, a clocked
// monitor and an in-bench model of the key counts and the report ring
`timescale 1ns / 1ps

module hid_keyboard_report_tracker_tb;
  import hkrt_pkg::*;

  localparam logic [2:0] ACT_UNUSED   = 3'd7;
  localparam int unsigned RANDOM_XFERS = 1250;
  localparam int unsigned HOLD_REPEATS = 258;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start_i;
  logic    busy_o;
  item_t   item_i;
  logic    done_o;
  res_t    result_o;

  // model state: held key slots, counts and the report ring
  logic [NUM_KEYS-1:0][7:0] held_keys = '0;
  logic [7:0]               key_cnt [NUM_KEYS] = '{default: '0};
  logic [7:0]               mod_cnt [NUM_MODS] = '{default: '0};
  logic [7:0]               shift_cnt = '0;
  entry_t                   ring_mem [QUEUE_DEPTH] = '{default: '0};
  int                       ring_head = 0;
  int                       ring_tail = 0;
  logic                     release_due = 1'b0;

  item_t key_events [$];
  res_t  tracked_results [$];
  logic  xfer_taken = 1'b0;
  int    gap_left = 0;
  int    err_cnt = 0;
  int    n_xfers = 0;
  int    n_polled = 0;
  int    n_dropped = 0;
  int    n_refused = 0;

  hid_keyboard_report_tracker u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ring write; returns 1 when the report is dropped
  function automatic logic ring_put(entry_t e);
    int nxt;
    int last;
    nxt = (ring_head + 1) % QUEUE_DEPTH;
    if (nxt == ring_tail) begin
      last = (ring_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
      // full ring: a state report folds into a newest state entry
      if (!e.one_shot && !ring_mem[last].one_shot) begin
        ring_mem[last] = e;
        return 1'b0;
      end
      return 1'b1;
    end
    ring_mem[ring_head] = e;
    ring_head = nxt;
    return 1'b0;
  endfunction

  // queue the report of the keys and modifiers currently held
  function automatic logic push_held_state();
    entry_t e;
    e = '0;
    for (int i = 0; i < NUM_MODS; i++) begin
      if (mod_cnt[i] != 8'd0) e.mods[i] = 1'b1;
    end
    if (shift_cnt != 8'd0) e.mods = e.mods | LEFT_SHIFT;
    e.keys = held_keys;
    return ring_put(e);
  endfunction

  // apply one key action to the model and return the result it should produce
  function automatic res_t apply_key_event(item_t it);
    res_t   r;
    entry_t e;
    int     slot;
    int     free_slot;
    logic   took;
    r = '0;
    e = '0;
    took = 1'b0;
    slot = -1;
    free_slot = -1;
    case (it.action)
      ACT_KEY_PRESS: begin
        if (it.key_code != 8'h00) begin
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (slot < 0) begin
              if (held_keys[i] == it.key_code) slot = i;
              else if (free_slot < 0 && held_keys[i] == 8'h00) free_slot = i;
            end
          end
          if (slot >= 0) begin
            if (key_cnt[slot] != COUNT_MAX) key_cnt[slot] = key_cnt[slot] + 8'd1;
            took = 1'b1;
          end else if (free_slot >= 0) begin
            held_keys[free_slot] = it.key_code;
            key_cnt[free_slot] = 8'd1;
            took = 1'b1;
          end
          if (took) begin
            if (it.needs_shift && shift_cnt != COUNT_MAX) shift_cnt = shift_cnt + 8'd1;
            r.report_lost = push_held_state();
            r.accepted = 1'b1;
          end
        end
      end
      ACT_KEY_RELEASE: begin
        if (it.key_code != 8'h00) begin
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (slot < 0 && held_keys[i] == it.key_code) slot = i;
          end
          if (slot >= 0) begin
            if (key_cnt[slot] != 8'd0) key_cnt[slot] = key_cnt[slot] - 8'd1;
            if (key_cnt[slot] == 8'd0) held_keys[slot] = 8'h00;
            if (it.needs_shift && shift_cnt != 8'd0) shift_cnt = shift_cnt - 8'd1;
            r.report_lost = push_held_state();
            r.accepted = 1'b1;
          end
        end
      end
      ACT_MOD_PRESS: begin
        if (mod_cnt[it.modifier_index] != COUNT_MAX) begin
          mod_cnt[it.modifier_index] = mod_cnt[it.modifier_index] + 8'd1;
        end
        r.report_lost = push_held_state();
        r.accepted = 1'b1;
      end
      ACT_MOD_RELEASE: begin
        if (mod_cnt[it.modifier_index] != 8'd0) begin
          mod_cnt[it.modifier_index] = mod_cnt[it.modifier_index] - 8'd1;
        end
        r.report_lost = push_held_state();
        r.accepted = 1'b1;
      end
      ACT_RELEASE_ALL: begin
        held_keys = '0;
        key_cnt = '{default: '0};
        mod_cnt = '{default: '0};
        shift_cnt = 8'd0;
        r.report_lost = push_held_state();
        r.accepted = 1'b1;
      end
      ACT_TYPE_ONCE: begin
        if (it.key_code != 8'h00) begin
          e.mods = it.needs_shift ? LEFT_SHIFT : 8'h00;
          e.keys[0] = it.key_code;
          e.one_shot = 1'b1;
          r.report_lost = ring_put(e);
          r.accepted = 1'b1;
        end
      end
      ACT_POLL: begin
        if (ring_head != ring_tail) begin
          r.report_valid = 1'b1;
          e = ring_mem[ring_tail];
          // second poll of a typed key gives the all-zero release report
          if (release_due) begin
            release_due = 1'b0;
            ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
          end else begin
            r.report_modifiers = e.mods;
            r.report_key0 = e.keys[0];
            r.report_key1 = e.keys[1];
            r.report_key2 = e.keys[2];
            r.report_key3 = e.keys[3];
            r.report_key4 = e.keys[4];
            r.report_key5 = e.keys[5];
            if (e.one_shot) release_due = 1'b1;
            else ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic item_t mk(action_e a, logic [7:0] k, logic s, logic [2:0] m);
    item_t it;
    it.action = a;
    it.key_code = k;
    it.needs_shift = s;
    it.modifier_index = m;
    return it;
  endfunction

  // idle cycles before the next transfer: mostly none, a few long
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || xfer_taken) begin
        xfer_taken = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (key_events.size() != 0) begin
          item_i <= key_events.pop_front();
          start_i <= 1'b1;
          gap_left = idle_cycles();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check strobed results, then predict for a transfer taken at this edge
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (tracked_results.size() == 0) begin
          err_cnt++;
          $display("%0t ns: result with none expected, got %h", $time, result_o);
        end else begin
          want = tracked_results.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(result_o.accepted));
          check_field("report_valid", 8'(want.report_valid), 8'(result_o.report_valid));
          check_field("report_modifiers", want.report_modifiers, result_o.report_modifiers);
          check_field("report_key0", want.report_key0, result_o.report_key0);
          check_field("report_key1", want.report_key1, result_o.report_key1);
          check_field("report_key2", want.report_key2, result_o.report_key2);
          check_field("report_key3", want.report_key3, result_o.report_key3);
          check_field("report_key4", want.report_key4, result_o.report_key4);
          check_field("report_key5", want.report_key5, result_o.report_key5);
          check_field("report_lost", 8'(want.report_lost), 8'(result_o.report_lost));
        end
      end
      if (start_i && !busy_o) begin
        want = apply_key_event(item_i);
        tracked_results.push_back(want);
        xfer_taken = 1'b1;
        n_xfers++;
        if (want.report_valid) n_polled++;
        if (want.report_lost) n_dropped++;
        if (!want.accepted && item_i.action != ACT_POLL) n_refused++;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] key_pool [8];
    logic [7:0] hold_key;
    logic [7:0] k;
    logic [2:0] hold_mod;
    int         n_sent;
    int         phase_left;
    int         poll_pct;
    int         roll;

    start_i = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;

    // directed: empty poll, unused code, zero key, release of a key not held
    key_events.push_back(mk(ACT_POLL, 8'h00, 1'b0, 3'd0));
    key_events.push_back(mk(action_e'(ACT_UNUSED), 8'hFF, 1'b1, 3'd7));
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h00, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_KEY_RELEASE, 8'h00, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_TYPE_ONCE, 8'h00, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_KEY_RELEASE, 8'h04, 1'b1, 3'd0));
    // modifier release at zero count still reports
    key_events.push_back(mk(ACT_MOD_RELEASE, 8'h00, 1'b0, 3'd7));
    // fill all six slots, then one more is refused
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h04, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h05, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h06, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h07, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h08, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_KEY_PRESS, 8'hFF, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h09, 1'b1, 3'd0));
    // key already held, modifiers, releases with shift
    key_events.push_back(mk(ACT_KEY_PRESS, 8'h04, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_MOD_PRESS, 8'h00, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_MOD_PRESS, 8'h00, 1'b0, 3'd7));
    key_events.push_back(mk(ACT_KEY_RELEASE, 8'h05, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_KEY_RELEASE, 8'h06, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_KEY_RELEASE, 8'h04, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_RELEASE_ALL, 8'h00, 1'b0, 3'd0));
    // typed key fills the ring; state and typed reports behind it are dropped
    key_events.push_back(mk(ACT_TYPE_ONCE, 8'hFF, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_MOD_PRESS, 8'h00, 1'b0, 3'd1));
    key_events.push_back(mk(ACT_TYPE_ONCE, 8'h3A, 1'b0, 3'd0));
    // one poll frees a slot, then a state report folds into the newest one
    key_events.push_back(mk(ACT_POLL, 8'h00, 1'b0, 3'd0));
    key_events.push_back(mk(ACT_MOD_PRESS, 8'h00, 1'b0, 3'd2));
    key_events.push_back(mk(ACT_MOD_RELEASE, 8'h00, 1'b0, 3'd2));

    // long hold: drive key, shift and modifier counts into saturation
    hold_key = 8'($urandom_range(1, 255));
    hold_mod = 3'($urandom_range(0, 7));
    for (int i = 0; i < HOLD_REPEATS; i++) begin
      key_events.push_back(mk(ACT_KEY_PRESS, hold_key, 1'b1, 3'($urandom_range(0, 7))));
    end
    for (int i = 0; i < HOLD_REPEATS; i++) begin
      key_events.push_back(mk(ACT_MOD_PRESS, 8'($urandom_range(0, 255)), 1'b0, hold_mod));
    end
    for (int i = 0; i < 20; i++) begin
      key_events.push_back(mk(ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7))));
    end
    key_events.push_back(mk(ACT_KEY_RELEASE, hold_key, 1'b1, 3'd0));
    key_events.push_back(mk(ACT_MOD_RELEASE, 8'h00, 1'b0, hold_mod));
    key_events.push_back(mk(ACT_RELEASE_ALL, 8'h00, 1'b0, 3'd0));
    n_sent = key_events.size();

    // random phases: filling, balanced and draining, each over a small key pool
    phase_left = 0;
    poll_pct = 35;
    while (n_sent < RANDOM_XFERS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 80);
        roll = $urandom_range(0, 2);
        poll_pct = (roll == 0) ? 10 : ((roll == 1) ? 35 : 70);
        foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(1, 255));
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      k = (roll < 85) ? key_pool[$urandom_range(0, 7)]
                      : ((roll < 90) ? 8'h00 : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < poll_pct) begin
        key_events.push_back(mk(ACT_POLL, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          key_events.push_back(mk(ACT_KEY_PRESS, k, 1'($urandom_range(0, 1)),
                                  3'($urandom_range(0, 7))));
        end else if (roll < 60) begin
          key_events.push_back(mk(ACT_KEY_RELEASE, k, 1'($urandom_range(0, 1)),
                                  3'($urandom_range(0, 7))));
        end else if (roll < 70) begin
          key_events.push_back(mk(ACT_MOD_PRESS, k, 1'($urandom_range(0, 1)),
                                  3'($urandom_range(0, 7))));
        end else if (roll < 80) begin
          key_events.push_back(mk(ACT_MOD_RELEASE, k, 1'($urandom_range(0, 1)),
                                  3'($urandom_range(0, 7))));
        end else if (roll < 84) begin
          key_events.push_back(mk(ACT_RELEASE_ALL, k, 1'($urandom_range(0, 1)),
                                  3'($urandom_range(0, 7))));
        end else if (roll < 95) begin
          key_events.push_back(mk(ACT_TYPE_ONCE, k, 1'($urandom_range(0, 1)),
                                  3'($urandom_range(0, 7))));
        end else begin
          // noise: any action code, unused one included
          key_events.push_back(mk(action_e'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
        end
      end
      n_sent++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain: every transfer taken and every result seen, then a short tail
    while (key_events.size() != 0 || start_i || tracked_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (tracked_results.size() != 0) begin
      err_cnt++;
      $display("%0t ns: %0d results never arrived", $time, tracked_results.size());
    end

    $display("run covered %0d transfers: %0d reports polled, %0d dropped on a full ring,",
             n_xfers, n_polled, n_dropped);
    $display("and %0d key actions refused or ignored; %0d mismatches", n_refused, err_cnt);
    if (err_cnt == 0) begin
      $display("hid_keyboard_report_tracker_tb: clean");
    end else begin
      $display("hid_keyboard_report_tracker_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout after %0t ns", $time);
    $display("hid_keyboard_report_tracker_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hkrt_pkg.sv
hw/rtl/hkrt_ram.sv
hw/rtl/hkrt_ctrl.sv
hw/rtl/hkrt_dp.sv
hw/rtl/hid_keyboard_report_tracker.sv
tb/sv/hid_keyboard_report_tracker_tb.sv
